>>> hw/rtl/vlo_pkg.sv
// ============================================================================
// vlo_pkg
// Shared types, constants and codes of the voxel log-odds occupancy store.
// ============================================================================
package vlo_pkg;

    // Store geometry
    localparam int VOXEL_COUNT = 32768;
    localparam int COUNT_WIDTH = 16;
    localparam int ADDR_W      = $clog2(VOXEL_COUNT);
    localparam int VADDR_W     = 15;
    localparam int OCC_W       = 16;
    localparam int OCCD_W      = 15;

    // Occupancy value of a voxel that has never been seen
    localparam logic [OCC_W-1:0] UNKNOWN_OCC = 16'h8000;

    // Configuration register reset values
    localparam logic [OCC_W-1:0]  HIT_RST  = 16'd217;
    localparam logic [OCC_W-1:0]  MISS_RST = 16'hFF62;   // -158
    localparam logic [OCC_W-1:0]  MIN_RST  = 16'hFE02;   // -510
    localparam logic [OCC_W-1:0]  MAX_RST  = 16'd890;
    localparam logic [OCCD_W-1:0] OCCD_RST = 15'd355;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OCCUPIED = 3'd4;

    // Item kinds
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_HIT     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MISS    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OUTSIDE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INSIDE  = 3'd4;

    // One stored voxel
    typedef struct packed {
        logic [OCC_W-1:0]       occ;
        logic [COUNT_WIDTH-1:0] hit;
        logic [COUNT_WIDTH-1:0] total;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Configuration register file
    typedef struct packed {
        logic [OCC_W-1:0]  hit_lo;
        logic [OCC_W-1:0]  miss_lo;
        logic [OCC_W-1:0]  min_lo;
        logic [OCC_W-1:0]  max_lo;
        logic [OCCD_W-1:0] occupied_lo;
    } t_cfg;

    // Result fields of one transaction
    typedef struct packed {
        logic [OCC_W-1:0] occ;
        logic             unknown;
        logic             changed;
    } t_res;

endpackage

>>> hw/rtl/voxel_log_odds_occupancy_update.sv
// A result passes through stage 1 and the output register once accepted.
// Throughput: one transaction per cycle while the output is not stalled;
// the single store RAM is read at acceptance and written back as stage 1
// retires, with the last write forwarded. Reset: configuration returns to
// defaults, then clearing writes all VOXEL_COUNT entries; input stalls.
// ============================================================================
// voxel_log_odds_occupancy_update
// Voxel occupancy store: Q8.8 log-odds plus hit and total counts per voxel,
// updated by observe, commit and reprojection transactions.
// ============================================================================
module voxel_log_odds_occupancy_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [vlo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vlo_pkg::OCC_W-1:0]     i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [vlo_pkg::KIND_W-1:0]    i_kind,
    input  logic [vlo_pkg::VADDR_W-1:0]   i_voxel_address,
    input  logic                          i_ray_blocked,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [vlo_pkg::VADDR_W-1:0]   o_voxel_address_res,
    output logic [vlo_pkg::OCC_W-1:0]     o_occupancy,
    output logic                          o_is_unknown,
    output logic                          o_changed
);

    localparam int AW = vlo_pkg::ADDR_W;

    vlo_pkg::t_cfg   r_cfg;
    vlo_pkg::t_entry ram_rdata;
    vlo_pkg::t_entry ram_wdata;
    vlo_pkg::t_entry old_entry;
    vlo_pkg::t_entry upd_entry;
    vlo_pkg::t_res   upd_res;
    vlo_pkg::t_entry r_wb_data;

    logic                        r_clr_busy;
    logic [AW-1:0]               r_clr_addr;
    logic                        r_s1_valid;
    logic [vlo_pkg::KIND_W-1:0]  r_s1_kind;
    logic [vlo_pkg::VADDR_W-1:0] r_s1_addr;
    logic                        r_s1_blocked;
    logic                        r_wb_valid;
    logic [vlo_pkg::VADDR_W-1:0] r_wb_addr;
    logic                        r_out_valid;
    logic [vlo_pkg::VADDR_W-1:0] r_out_addr;
    vlo_pkg::t_res               r_out_res;

    logic                        in_accept;
    logic                        s1_go;
    logic                        s1_in_range;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hit_lo      <= vlo_pkg::HIT_RST;
            r_cfg.miss_lo     <= vlo_pkg::MISS_RST;
            r_cfg.min_lo      <= vlo_pkg::MIN_RST;
            r_cfg.max_lo      <= vlo_pkg::MAX_RST;
            r_cfg.occupied_lo <= vlo_pkg::OCCD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vlo_pkg::CFG_HIT:      r_cfg.hit_lo      <= i_cfg_data;
                vlo_pkg::CFG_MISS:     r_cfg.miss_lo     <= i_cfg_data;
                vlo_pkg::CFG_MIN:      r_cfg.min_lo      <= i_cfg_data;
                vlo_pkg::CFG_MAX:      r_cfg.max_lo      <= i_cfg_data;
                vlo_pkg::CFG_OCCUPIED: r_cfg.occupied_lo <= i_cfg_data[vlo_pkg::OCCD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: stage 1 retires when the output register frees up
    assign s1_go      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_go);
    assign in_accept  = i_in_valid && !o_in_stall;

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(vlo_pkg::VOXEL_COUNT - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Store RAM write port: clearing pass or write-back of stage 1
    assign s1_in_range = 32'(r_s1_addr) < vlo_pkg::VOXEL_COUNT;
    always_comb begin
        if (r_clr_busy) begin
            ram_we          = 1'b1;
            ram_waddr       = r_clr_addr;
            ram_wdata.occ   = vlo_pkg::UNKNOWN_OCC;
            ram_wdata.hit   = '0;
            ram_wdata.total = '0;
        end else begin
            ram_we    = s1_go && s1_in_range;
            ram_waddr = r_s1_addr[AW-1:0];
            ram_wdata = upd_entry;
        end
    end

    vlo_ram #(
        .WIDTH (vlo_pkg::ENTRY_W),
        .DEPTH (vlo_pkg::VOXEL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (i_voxel_address[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Stage 1: transaction waiting on its read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_kind    <= i_kind;
            r_s1_addr    <= i_voxel_address;
            r_s1_blocked <= i_ray_blocked;
        end
    end

    // Forward the last write-back over the RAM's old read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_valid <= 1'b0;
        end else if (r_clr_busy) begin
            r_wb_valid <= 1'b0;
        end else if (ram_we) begin
            r_wb_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we && !r_clr_busy) begin
            r_wb_addr <= r_s1_addr;
            r_wb_data <= upd_entry;
        end
    end

    assign old_entry = (r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : ram_rdata;

    vlo_calc u_calc (
        .i_kind        (r_s1_kind),
        .i_ray_blocked (r_s1_blocked),
        .i_in_range    (s1_in_range),
        .i_entry       (old_entry),
        .i_cfg         (r_cfg),
        .o_entry       (upd_entry),
        .o_res         (upd_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_addr <= r_s1_addr;
            r_out_res  <= upd_res;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_voxel_address_res = r_out_addr;
    assign o_occupancy         = r_out_res.occ;
    assign o_is_unknown        = r_out_res.unknown;
    assign o_changed           = r_out_res.changed;

    // Checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_in_stall)
        else $error("transaction accepted during clearing pass");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted transaction lost before stage 1");

    a_retire_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && s1_in_range) |-> (ram_we && (ram_waddr == r_s1_addr[AW-1:0])))
        else $error("retired transaction not written back");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_res)))
        else $error("stalled result overwritten");

endmodule

>>> hw/rtl/vlo_ram.sv
// ============================================================================
// vlo_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address read and write).
// ============================================================================
module vlo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/vlo_calc.sv
// ============================================================================
// vlo_calc
// Update datapath: given the stored voxel and one transaction, forms the
// new stored voxel and the result fields.
// ============================================================================
module vlo_calc (
    input  logic [vlo_pkg::KIND_W-1:0] i_kind,
    input  logic                       i_ray_blocked,
    input  logic                       i_in_range,
    input  vlo_pkg::t_entry            i_entry,
    input  vlo_pkg::t_cfg              i_cfg,
    output vlo_pkg::t_entry            o_entry,
    output vlo_pkg::t_res              o_res
);

    localparam int CW = vlo_pkg::COUNT_WIDTH;
    localparam int OW = vlo_pkg::OCC_W;

    logic signed [17:0] occ_x;
    logic signed [17:0] hit_x;
    logic signed [17:0] miss_x;
    logic signed [17:0] min_x;
    logic signed [17:0] max_x;
    logic signed [17:0] occd_x;
    logic signed [17:0] inc_x;
    logic signed [17:0] thr_x;
    logic signed [17:0] sum_x;
    logic signed [17:0] cmt_x;
    logic signed [17:0] out_x;
    logic signed [17:0] ins_x;
    logic [CW-1:0]      hit_inc;
    logic [CW-1:0]      tot_inc;
    logic [CW-1:0]      miss_cnt;
    logic               use_hit;
    logic               inc_ge0;
    logic               inc_le0;
    logic [OW-1:0]      new_occ;

    // Extend operands to a common width: signed fields by sign, the occupied level by zeros
    assign occ_x  = {{2{i_entry.occ[OW-1]}}, i_entry.occ};
    assign hit_x  = {{2{i_cfg.hit_lo[OW-1]}}, i_cfg.hit_lo};
    assign miss_x = {{2{i_cfg.miss_lo[OW-1]}}, i_cfg.miss_lo};
    assign min_x  = {{2{i_cfg.min_lo[OW-1]}}, i_cfg.min_lo};
    assign max_x  = {{2{i_cfg.max_lo[OW-1]}}, i_cfg.max_lo};
    assign occd_x = {3'b000, i_cfg.occupied_lo};

    // Saturating counters
    assign hit_inc = (i_entry.hit == '1) ? i_entry.hit : i_entry.hit + CW'(1);
    assign tot_inc = (i_entry.total == '1) ? i_entry.total : i_entry.total + CW'(1);

    // Majority vote of the commit
    assign miss_cnt = (i_entry.total >= i_entry.hit) ? i_entry.total - i_entry.hit : '0;
    assign use_hit  = (i_entry.hit >= miss_cnt) && (i_entry.hit != '0);
    assign inc_x    = use_hit ? hit_x : miss_x;
    assign inc_ge0  = !inc_x[17];
    assign inc_le0  = inc_x[17] || (inc_x == '0);
    assign sum_x    = occ_x + inc_x;

    // Commit clamp rules
    always_comb begin
        if (inc_ge0 && (occ_x >= max_x)) begin
            cmt_x = occ_x;
        end else if (inc_le0 && (occ_x == min_x)) begin
            cmt_x = occ_x;
        end else if (inc_le0 && (occ_x < min_x)) begin
            cmt_x = min_x;
        end else begin
            // lower clamp first, then upper: max wins when min lies above max
            cmt_x = (sum_x < min_x) ? min_x : sum_x;
            if (cmt_x > max_x) begin
                cmt_x = max_x;
            end
        end
    end

    // Reprojection adjustments
    assign thr_x = occd_x + hit_x;
    always_comb begin
        out_x = occ_x - (occd_x >>> 2);
        if (out_x < min_x) begin
            out_x = min_x;
        end
        ins_x = occ_x + (occd_x >>> 1);
        if (ins_x > max_x) begin
            ins_x = max_x;
        end
    end

    // Select the update by kind
    always_comb begin
        o_entry = i_entry;
        new_occ = i_entry.occ;
        case (i_kind)
            vlo_pkg::KIND_HIT: begin
                o_entry.hit   = hit_inc;
                o_entry.total = tot_inc;
            end
            vlo_pkg::KIND_MISS: begin
                o_entry.total = tot_inc;
            end
            vlo_pkg::KIND_COMMIT: begin
                o_entry.hit   = '0;
                o_entry.total = '0;
                new_occ       = cmt_x[OW-1:0];
            end
            vlo_pkg::KIND_OUTSIDE: begin
                if (occ_x < thr_x) begin
                    new_occ = out_x[OW-1:0];
                end
            end
            vlo_pkg::KIND_INSIDE: begin
                if (!i_ray_blocked) begin
                    new_occ = ins_x[OW-1:0];
                end
            end
            default: begin
                new_occ = i_entry.occ;
            end
        endcase
        o_entry.occ = new_occ;
    end

    // Result fields
    always_comb begin
        o_res.occ     = i_in_range ? new_occ : vlo_pkg::UNKNOWN_OCC;
        o_res.unknown = $signed(o_res.occ) < $signed(i_cfg.min_lo);
        o_res.changed = i_in_range && (new_occ != i_entry.occ);
    end

endmodule

>>> test/tb.sv
// ============================================================================
// tb
// Self-checking bench for the voxel log-odds occupancy store. A per-item
// mirror of the voxel store predicts every result; stimulus covers observe,
// commit and reprojection transactions under several register settings,
// commit majority votes, random idling on both channels and output
// backpressure.
// ============================================================================
module tb;

    localparam int CLK_HALF       = 4;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int HOLD_CYCLES    = 200;

    // codes past the end of the defined lists
    localparam logic [vlo_pkg::KIND_W-1:0]    KIND_LAST = '1;
    localparam logic [vlo_pkg::CFG_IDX_W-1:0] CFG_LAST  = '1;

    typedef struct packed {
        logic [vlo_pkg::VADDR_W-1:0] addr;
        vlo_pkg::t_res               res;
    } t_voxel_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [vlo_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [vlo_pkg::OCC_W-1:0]     i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic [vlo_pkg::KIND_W-1:0]    i_kind;
    logic [vlo_pkg::VADDR_W-1:0]   i_voxel_address;
    logic                          i_ray_blocked;
    logic                          o_out_valid;
    logic                          i_out_stall;
    logic [vlo_pkg::VADDR_W-1:0]   o_voxel_address_res;
    logic [vlo_pkg::OCC_W-1:0]     o_occupancy;
    logic                          o_is_unknown;
    logic                          o_changed;

    voxel_log_odds_occupancy_update i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_kind              (i_kind),
        .i_voxel_address     (i_voxel_address),
        .i_ray_blocked       (i_ray_blocked),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_voxel_address_res (o_voxel_address_res),
        .o_occupancy         (o_occupancy),
        .o_is_unknown        (o_is_unknown),
        .o_changed           (o_changed)
    );

    // Mirror of the voxel store and the register file
    logic signed [vlo_pkg::OCC_W-1:0] occupancy_mirror   [vlo_pkg::VOXEL_COUNT];
    logic [vlo_pkg::COUNT_WIDTH-1:0]  hit_count_mirror   [vlo_pkg::VOXEL_COUNT];
    logic [vlo_pkg::COUNT_WIDTH-1:0]  total_count_mirror [vlo_pkg::VOXEL_COUNT];
    logic signed [vlo_pkg::OCC_W-1:0] cfg_hit;
    logic signed [vlo_pkg::OCC_W-1:0] cfg_miss;
    logic signed [vlo_pkg::OCC_W-1:0] cfg_min;
    logic signed [vlo_pkg::OCC_W-1:0] cfg_max;
    logic [vlo_pkg::OCCD_W-1:0]       cfg_occupied;

    t_voxel_result               expected_voxel_results [$];
    logic [vlo_pkg::VADDR_W-1:0] voxel_pool [$];
    int                          mismatch_count;
    int                          items_sent;
    bit                          tx_idling;
    bit                          rx_idling;
    bit                          hold_request;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [vlo_pkg::COUNT_WIDTH-1:0] bump_count(
        input logic [vlo_pkg::COUNT_WIDTH-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic int clip_occupancy(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic t_voxel_result predict_voxel_update(
        input logic [vlo_pkg::KIND_W-1:0]  kind,
        input logic [vlo_pkg::VADDR_W-1:0] addr,
        input logic                        blocked);
        t_voxel_result                   r;
        int                              old_occ;
        int                              new_occ;
        int                              step;
        int                              hit_lo;
        int                              miss_lo;
        int                              lo;
        int                              hi;
        int                              level;
        logic [vlo_pkg::COUNT_WIDTH-1:0] hits;
        logic [vlo_pkg::COUNT_WIDTH-1:0] misses;
        logic [vlo_pkg::COUNT_WIDTH-1:0] total;
        hit_lo  = cfg_hit;
        miss_lo = cfg_miss;
        lo      = cfg_min;
        hi      = cfg_max;
        level   = cfg_occupied;
        old_occ = occupancy_mirror[addr];
        new_occ = old_occ;
        case (kind)
            vlo_pkg::KIND_HIT: begin
                hit_count_mirror[addr]   = bump_count(hit_count_mirror[addr]);
                total_count_mirror[addr] = bump_count(total_count_mirror[addr]);
            end
            vlo_pkg::KIND_MISS: begin
                total_count_mirror[addr] = bump_count(total_count_mirror[addr]);
            end
            vlo_pkg::KIND_COMMIT: begin
                hits   = hit_count_mirror[addr];
                total  = total_count_mirror[addr];
                misses = (total >= hits) ? total - hits : '0;
                step   = (hits >= misses && hits != 0) ? hit_lo : miss_lo;
                hit_count_mirror[addr]   = '0;
                total_count_mirror[addr] = '0;
                // clamp rules, first match wins
                if (step >= 0 && old_occ >= hi) begin
                    new_occ = old_occ;
                end else if (step <= 0 && old_occ == lo) begin
                    new_occ = old_occ;
                end else if (step <= 0 && old_occ < lo) begin
                    new_occ = lo;
                end else begin
                    new_occ = old_occ + step;
                    if (new_occ < lo) new_occ = lo;
                    if (new_occ > hi) new_occ = hi;
                    new_occ = clip_occupancy(new_occ);
                end
            end
            vlo_pkg::KIND_OUTSIDE: begin
                // only voxels below the weak-occupancy threshold are lowered
                if (old_occ < level + hit_lo) begin
                    new_occ = old_occ - (level >> 2);
                    if (new_occ < lo) new_occ = lo;
                    new_occ = clip_occupancy(new_occ);
                end
            end
            vlo_pkg::KIND_INSIDE: begin
                if (!blocked) begin
                    new_occ = old_occ + (level >> 1);
                    if (new_occ > hi) new_occ = hi;
                    new_occ = clip_occupancy(new_occ);
                end
            end
            default: ;
        endcase
        occupancy_mirror[addr] = new_occ[vlo_pkg::OCC_W-1:0];
        r.addr        = addr;
        r.res.occ     = new_occ[vlo_pkg::OCC_W-1:0];
        r.res.unknown = (new_occ < lo);
        r.res.changed = (new_occ != old_occ);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: predict on each accepted transaction, compare each result
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_voxel_result want;
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_voxel_results.insert(expected_voxel_results.size(),
                predict_voxel_update(i_kind, i_voxel_address, i_ray_blocked));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_voxel_results.size() == 0) begin
                report_mismatch($sformatf("result for voxel %0d with nothing pending",
                                          o_voxel_address_res));
            end else begin
                want = expected_voxel_results.pop_front();
                if (o_voxel_address_res !== want.addr)
                    report_mismatch($sformatf("address %0d, want %0d",
                                              o_voxel_address_res, want.addr));
                if (o_occupancy !== want.res.occ)
                    report_mismatch($sformatf("voxel %0d occupancy %0d, want %0d", want.addr,
                                              $signed(o_occupancy), $signed(want.res.occ)));
                if (o_is_unknown !== want.res.unknown)
                    report_mismatch($sformatf("voxel %0d unknown %b, want %b", want.addr,
                                              o_is_unknown, want.res.unknown));
                if (o_changed !== want.res.changed)
                    report_mismatch($sformatf("voxel %0d changed %b, want %b", want.addr,
                                              o_changed, want.res.changed));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, or one long hold on request
    // ------------------------------------------------------------------------
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                i_out_stall <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Leaves valid high so that the next transaction can follow directly;
    // drain_results lowers it.
    task automatic send_item(input logic [vlo_pkg::KIND_W-1:0] kind,
                             input logic [vlo_pkg::VADDR_W-1:0] addr,
                             input logic blocked);
        if (tx_idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_voxel_address <= addr;
        i_ray_blocked   <= blocked;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Must be called in the cycle the last transaction was accepted
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_voxel_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [vlo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vlo_pkg::OCC_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            vlo_pkg::CFG_HIT:      cfg_hit      = data;
            vlo_pkg::CFG_MISS:     cfg_miss     = data;
            vlo_pkg::CFG_MIN:      cfg_min      = data;
            vlo_pkg::CFG_MAX:      cfg_max      = data;
            vlo_pkg::CFG_OCCUPIED: cfg_occupied = data[vlo_pkg::OCCD_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes every register, plus one index past the list that must be ignored
    task automatic set_config(input int hit, input int miss, input int lo, input int hi,
                              input int level);
        cfg_write(vlo_pkg::CFG_HIT, hit[vlo_pkg::OCC_W-1:0]);
        cfg_write(vlo_pkg::CFG_MISS, miss[vlo_pkg::OCC_W-1:0]);
        cfg_write(vlo_pkg::CFG_MIN, lo[vlo_pkg::OCC_W-1:0]);
        cfg_write(vlo_pkg::CFG_MAX, hi[vlo_pkg::OCC_W-1:0]);
        cfg_write(vlo_pkg::CFG_OCCUPIED,
                  {1'($urandom_range(0, 1)), level[vlo_pkg::OCCD_W-1:0]});
        cfg_write(vlo_pkg::CFG_IDX_W'($urandom_range(vlo_pkg::CFG_OCCUPIED + 1, CFG_LAST)),
                  vlo_pkg::OCC_W'($urandom));
    endtask

    task automatic randomize_config();
        int hit;
        int miss;
        int lo;
        int hi;
        int level;
        if ($urandom_range(0, 1)) begin
            // typical sensor-model values
            hit   = $urandom_range(0, 600);
            miss  = -int'($urandom_range(0, 600));
            lo    = -int'($urandom_range(100, 2000));
            hi    = $urandom_range(0, 2000);
            level = $urandom_range(0, 1200);
        end else begin
            hit   = $urandom_range(0, 65535) - 32768;
            miss  = $urandom_range(0, 65535) - 32768;
            lo    = $urandom_range(0, 65534) - 32767;
            hi    = $urandom_range(0, 65534) - 32767;
            level = $urandom_range(0, 32767);
        end
        set_config(hit, miss, lo, hi, level);
    endtask

    task automatic fill_pool(input int n);
        voxel_pool.delete();
        if ($urandom_range(0, 3) == 0)
            voxel_pool.insert(voxel_pool.size(), vlo_pkg::VADDR_W'(0));
        if ($urandom_range(0, 3) == 0)
            voxel_pool.insert(voxel_pool.size(), {vlo_pkg::VADDR_W{1'b1}});
        repeat (n) voxel_pool.insert(voxel_pool.size(), vlo_pkg::VADDR_W'($urandom));
    endtask

    function automatic logic [vlo_pkg::VADDR_W-1:0] pick_voxel();
        if ($urandom_range(0, 9) == 0) return vlo_pkg::VADDR_W'($urandom);
        return voxel_pool[$urandom_range(0, voxel_pool.size() - 1)];
    endfunction

    // Any single transaction, undefined kinds included
    task automatic send_random_item();
        int                         pick;
        logic [vlo_pkg::KIND_W-1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 35)      kind = vlo_pkg::KIND_HIT;
        else if (pick < 60) kind = vlo_pkg::KIND_MISS;
        else if (pick < 75) kind = vlo_pkg::KIND_COMMIT;
        else if (pick < 85) kind = vlo_pkg::KIND_OUTSIDE;
        else if (pick < 95) kind = vlo_pkg::KIND_INSIDE;
        else kind = vlo_pkg::KIND_W'($urandom_range(vlo_pkg::KIND_INSIDE + 1, KIND_LAST));
        send_item(kind, pick_voxel(), 1'($urandom_range(0, 1)));
    endtask

    // Observations of one voxel closed by a commit, sometimes a reprojection
    task automatic send_voxel_sequence();
        logic [vlo_pkg::VADDR_W-1:0] addr;
        int                          hit_pct;
        addr    = pick_voxel();
        hit_pct = $urandom_range(0, 100);
        repeat ($urandom_range(1, 6))
            send_item(($urandom_range(0, 99) < hit_pct) ? vlo_pkg::KIND_HIT
                                                         : vlo_pkg::KIND_MISS,
                      addr, 1'($urandom_range(0, 1)));
        send_item(vlo_pkg::KIND_COMMIT, addr, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) < 3)
            send_item($urandom_range(0, 1) ? vlo_pkg::KIND_OUTSIDE : vlo_pkg::KIND_INSIDE,
                      addr, 1'($urandom_range(0, 1)));
    endtask

    task automatic run_traffic(input int n, input int seq_pct);
        int target;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < seq_pct) send_voxel_sequence();
            else send_random_item();
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset register values, unknown voxels and every clamp path
    task automatic test_reset_defaults();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        send_item(vlo_pkg::KIND_COMMIT, 15'd0, 1'b0);     // unknown, no counts: set to min
        send_item(vlo_pkg::KIND_INSIDE, 15'h5555, 1'b1);  // occluded: no change
        send_item(vlo_pkg::KIND_INSIDE, 15'h5555, 1'b0);  // raised but still unknown
        send_item(vlo_pkg::KIND_OUTSIDE, 15'h2AAA, 1'b0); // lowered, clamped at min
        send_item(vlo_pkg::KIND_MISS, 15'h2AAA, 1'b0);
        send_item(vlo_pkg::KIND_COMMIT, 15'h2AAA, 1'b0);  // at min: kept
        send_item(vlo_pkg::KIND_HIT, 15'h7FFF, 1'b0);
        send_item(vlo_pkg::KIND_MISS, 15'h7FFF, 1'b0);
        send_item(vlo_pkg::KIND_COMMIT, 15'h7FFF, 1'b0);  // tie goes to the hit side
        send_item(vlo_pkg::KIND_HIT, 15'h7FFF, 1'b0);
        send_item(vlo_pkg::KIND_HIT, 15'h7FFF, 1'b0);
        send_item(vlo_pkg::KIND_MISS, 15'h7FFF, 1'b0);
        send_item(vlo_pkg::KIND_COMMIT, 15'h7FFF, 1'b0);
        send_item(vlo_pkg::KIND_OUTSIDE, 15'h7FFF, 1'b0);
        // climb to the upper clamp, then try to pass it
        repeat (8) send_item(vlo_pkg::KIND_INSIDE, 15'd0, 1'b0);
        send_item(vlo_pkg::KIND_HIT, 15'd0, 1'b1);
        send_item(vlo_pkg::KIND_COMMIT, 15'd0, 1'b0);     // at max with a positive step: kept
        send_item(vlo_pkg::KIND_OUTSIDE, 15'd0, 1'b0);    // strongly occupied: untouched
        for (int k = vlo_pkg::KIND_INSIDE + 1; k <= KIND_LAST; k++)
            send_item(vlo_pkg::KIND_W'(k), 15'h7FFF, 1'b1);
        drain_results();
    endtask

    // Majority vote of the commit: ties, misses ahead, cleared counts
    task automatic test_count_majority();
        tx_idling = 1'b0;
        rx_idling = 1'b1;
        repeat (3) send_item(vlo_pkg::KIND_HIT, 15'h1234, 1'b0);
        repeat (3) send_item(vlo_pkg::KIND_MISS, 15'h1234, 1'b0);
        send_item(vlo_pkg::KIND_COMMIT, 15'h1234, 1'b0);   // tie: hit step
        repeat (2) send_item(vlo_pkg::KIND_HIT, 15'h4321, 1'b0);
        repeat (3) send_item(vlo_pkg::KIND_MISS, 15'h4321, 1'b0);
        send_item(vlo_pkg::KIND_COMMIT, 15'h4321, 1'b0);   // misses ahead: miss step
        send_item(vlo_pkg::KIND_COMMIT, 15'h4321, 1'b0);   // counts cleared: miss step
        repeat (4) send_item(vlo_pkg::KIND_MISS, 15'h1234, 1'b0);
        send_item(vlo_pkg::KIND_COMMIT, 15'h1234, 1'b0);
        drain_results();
    endtask

    // Register extremes, min above max, zero steps
    task automatic test_config_extremes();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: set_config(32767, -32768, -32767, 32767, 32767);
                1: set_config(-32768, 32767, 32767, -32767, 0);
                2: set_config(0, 0, 0, 0, 1);
                3: set_config(-1, 1, -32767, -32767, 32766);
                default: set_config(32767, -32768, 32767, 32767, 32767);
            endcase
            fill_pool(4);
            run_traffic(30, 60);
            drain_results();
        end
    endtask

    // Long receiver hold while the sender keeps offering transactions
    task automatic test_output_backpressure();
        set_config(217, -158, -510, 890, 355);
        tx_idling    = 1'b0;
        rx_idling    = 1'b0;
        fill_pool(3);
        hold_request = 1'b1;
        run_traffic(48, 50);
        drain_results();
    endtask

    task automatic test_random_traffic();
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        repeat (6) begin
            randomize_config();
            fill_pool($urandom_range(2, 12));
            run_traffic(60, 70);
            drain_results();
        end
    endtask

    // Back-to-back transactions on very few voxels, no idling anywhere
    task automatic test_streaming();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        set_config(300, -200, -800, 1200, 500);
        fill_pool(3);
        run_traffic(150, 30);
        drain_results();
    endtask

    task automatic finish_run();
        for (int k = 0; k < 10000 && expected_voxel_results.size() != 0; k++)
            @(posedge i_clk);
        if (expected_voxel_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      expected_voxel_results.size()));
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_kind          = '0;
        i_voxel_address = '0;
        i_ray_blocked   = 1'b0;
        mismatch_count  = 0;
        items_sent      = 0;
        tx_idling       = 1'b0;
        rx_idling       = 1'b0;
        hold_request    = 1'b0;
        for (int a = 0; a < vlo_pkg::VOXEL_COUNT; a++) begin
            occupancy_mirror[a]   = vlo_pkg::UNKNOWN_OCC;
            hit_count_mirror[a]   = '0;
            total_count_mirror[a] = '0;
        end
        cfg_hit      = vlo_pkg::HIT_RST;
        cfg_miss     = vlo_pkg::MISS_RST;
        cfg_min      = vlo_pkg::MIN_RST;
        cfg_max      = vlo_pkg::MAX_RST;
        cfg_occupied = vlo_pkg::OCCD_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_count_majority();
        test_config_extremes();
        test_output_backpressure();
        test_random_traffic();
        test_streaming();
        finish_run();
    end

endmodule
